// ===== design/credit_flow_tx_queue_top_assert.svh =====
// Assertion macros for the credit flow transmit queue checker.
`ifndef CREDIT_FLOW_TX_QUEUE_TOP_ASSERT_SVH
`define CREDIT_FLOW_TX_QUEUE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CFTQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define CFTQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/cftq_pkg.sv =====
// Types and constants shared by the credit flow transmit queue modules.
`default_nettype none
package cftq_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_ARRIVE = 2'd1,
        FUNC_LOAD   = 2'd2,
        FUNC_RETURN = 2'd3
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [15:0] packet_id;
        logic [15:0] duration;
        logic [15:0] credit_value;
    } t_in_word;

    typedef struct packed {
        logic        send_valid;
        logic [15:0] sent_packet_id;
        logic        dropped;
        logic [6:0]  queue_length;
        logic [15:0] credits_left;
        logic        server_busy;
    } t_out_word;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] dur;
    } t_entry;

    localparam logic [6:0]  LIMIT_RESET = 7'd64;
    localparam logic [15:0] CREDIT_MAX  = 16'hFFFF;

endpackage
`default_nettype wire

// ===== design/cftq_in_reg.sv =====
// Input register stage holding one accepted word until the core takes it.
`default_nettype none
module cftq_in_reg
    import cftq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_data,
    output logic          o_valid,
    input  wire logic     i_take,
    output t_in_word      o_data
);

    logic     r_valid;
    t_in_word r_data;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/cftq_store.sv =====
// Packet store memory with registered read and write-to-read bypass.
`default_nettype none
module cftq_store
    import cftq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int PTR_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [PTR_W-1:0] i_wr_addr,
    input  wire t_entry           i_wr_data,
    input  wire logic [PTR_W-1:0] i_rd_addr,
    output t_entry                o_rd_data
);

    t_entry mem [DEPTH];
    t_entry r_rd_data;
    t_entry r_byp_data;
    logic   r_byp_sel;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= mem[i_rd_addr];
        r_byp_sel  <= i_wr_en && (i_wr_addr == i_rd_addr);
        r_byp_data <= i_wr_data;
    end

    assign o_rd_data = r_byp_sel ? r_byp_data : r_rd_data;

endmodule
`default_nettype wire

// ===== design/credit_flow_tx_queue_top.sv =====
// Credit gated drop-tail transmit queue, top level.
//
//  channel  | valid       | ready        | data
//  ---------+-------------+--------------+------------------------
//  in       | i_in_valid  | o_in_ready   | i_in_data  (t_in_word)
//  out      | o_out_valid | i_out_ready  | o_out_data (t_out_word)
//  cfg      | i_cfg_valid | o_cfg_ready  | i_cfg_data (queue limit)
//
// One word per cycle sustained while the result register is not stalled; each word
// passes the input register, then a single-pass update into the result register.
// The store read is registered and re-issued every cycle at the next head address.
// Reset is synchronous; the store is not cleared; its data is only used once written.
// A stalled result register holds the input register; a full one holds o_in_ready low.
`default_nettype none
module credit_flow_tx_queue_top
    import cftq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_word   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_word       o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [6:0] i_cfg_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] inc;
        inc = {1'b0, p} + (PTR_W+1)'(1);
        return (inc == (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : inc[PTR_W-1:0];
    endfunction

    t_in_word         s_word;
    logic             s_valid;
    logic             s_take;
    logic             s_fire;
    t_entry           s_head;
    t_entry           s_in_entry;
    t_entry           s_disp;
    logic [PTR_W-1:0] s_rd_addr;
    logic             s_wr;
    logic [CMP_W-1:0] s_limit;
    logic [CMP_W-1:0] s_lim_ext;
    logic             s_drop;
    logic             s_send;

    logic [6:0]       r_limit;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_credit, n_credit;
    logic             r_busy, n_busy;
    logic [15:0]      r_cd, n_cd;
    logic             r_out_valid;
    t_out_word        r_out;

    assign o_cfg_ready = 1'b1;
    assign s_take      = !r_out_valid || i_out_ready;
    assign s_fire      = s_valid && s_take;

    cftq_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (s_valid),
        .i_take  (s_take),
        .o_data  (s_word)
    );

    assign s_in_entry = '{id: s_word.packet_id, dur: s_word.duration};
    assign s_rd_addr  = s_fire ? n_head : r_head;

    cftq_store #(
        .DEPTH (QUEUE_DEPTH),
        .PTR_W (PTR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (s_fire && s_wr),
        .i_wr_addr (r_tail),
        .i_wr_data (s_in_entry),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_head)
    );

    assign s_lim_ext = CMP_W'(r_limit);
    assign s_limit   = (s_lim_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : s_lim_ext;
    // empty queue: the arriving packet is the head
    assign s_disp    = (r_count == '0) ? s_in_entry : s_head;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_credit = r_credit;
        n_busy   = r_busy;
        n_cd     = r_cd;
        s_wr     = 1'b0;
        s_drop   = 1'b0;
        s_send   = 1'b0;
        unique case (s_word.func)
            FUNC_TICK: begin
                if (r_busy) begin
                    if (r_cd != '0) begin
                        n_cd = r_cd - 16'd1;
                    end
                    if (n_cd == '0) begin
                        n_busy = 1'b0;
                    end
                end
            end
            FUNC_ARRIVE: begin
                if (CMP_W'(r_count) >= s_limit) begin
                    s_drop = 1'b1;
                end else begin
                    s_wr    = 1'b1;
                    n_tail  = next_slot(r_tail);
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_LOAD: begin
                n_credit = s_word.credit_value;
            end
            FUNC_RETURN: begin
                if (r_credit != CREDIT_MAX) begin
                    n_credit = r_credit + 16'd1;
                end
            end
            default: begin
            end
        endcase
        if (!n_busy && n_count != '0 && n_credit != '0) begin
            s_send   = 1'b1;
            n_head   = next_slot(r_head);
            n_count  = n_count - CNT_W'(1);
            n_credit = n_credit - 16'd1;
            n_cd     = (s_disp.dur == '0) ? 16'd1 : s_disp.dur;
            n_busy   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_credit    <= '0;
            r_busy      <= 1'b0;
            r_cd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (s_fire) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_credit    <= n_credit;
                r_busy      <= n_busy;
                r_cd        <= n_cd;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out.send_valid     <= s_send;
            r_out.sent_packet_id <= s_send ? s_disp.id : 16'd0;
            r_out.dropped        <= s_drop;
            r_out.queue_length   <= 7'(n_count);
            r_out.credits_left   <= n_credit;
            r_out.server_busy    <= n_busy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== design/cftq_checker.sv =====
// Port-level checker for the credit flow transmit queue, with its bind.
`default_nettype none
`include "credit_flow_tx_queue_top_assert.svh"
module cftq_checker
    import cftq_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_word o_out_data
);

    `CFTQ_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `CFTQ_ASSERT_SAME(a_id_zero, o_out_valid && !o_out_data.send_valid, o_out_data.sent_packet_id == 16'd0)
    `CFTQ_ASSERT_SAME(a_send_busy, o_out_valid && o_out_data.send_valid, o_out_data.server_busy)
    `CFTQ_ASSERT_SAME(a_idle_starved, o_out_valid && o_out_data.queue_length != 7'd0 && !o_out_data.server_busy, o_out_data.credits_left == 16'd0)

endmodule

bind credit_flow_tx_queue_top cftq_checker u_cftq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
